### design/tsp_pkg.sv
// Shared types, constants and the square-root step of the speed profile block.
package tsp_pkg;

    localparam int WORD_W      = 32;
    localparam int SQ_W        = 2 * WORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int REM_W       = WORD_W + 3;
    localparam int CFG_IDX_W   = 3;
    localparam int ROOT_STEPS  = WORD_W;
    localparam int DIV_STEPS   = SQ_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIST = 3'd0,
        REG_VMAX = 3'd1,
        REG_ACC  = 3'd2,
        REG_VEND = 3'd3,
        REG_VBEG = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] vmax;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] vend;
        logic [WORD_W-1:0] vbeg;
    } cfg_t;

    typedef struct packed {
        logic                     degenerate;
        logic                     busy;
        logic [WORD_W-1:0]        peak;
        logic signed [DIST_W-1:0] accel_end;
        logic signed [DIST_W-1:0] decel_start;
        logic [SQ_W-1:0]          vbeg2;
        logic [SQ_W-1:0]          vend2;
    } derive_t;

    typedef struct packed {
        phase_t            phase;
        logic              use_root;
        logic [WORD_W-1:0] direct;
        logic [SQ_W-1:0]   arg;
    } q_item_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [WORD_W-1:0] root;
        logic [SQ_W-1:0]   x;
    } root_st_t;

    function automatic root_st_t root_step(root_st_t s);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        root_st_t         r;
        cur   = {s.rem[REM_W-3:0], s.x[SQ_W-1:SQ_W-2]};
        trial = {1'b0, s.root, 2'b01};
        r.x   = {s.x[SQ_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            r.rem  = cur - trial;
            r.root = {s.root[WORD_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cur;
            r.root = {s.root[WORD_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### design/tsp_if.sv
// Request channels of the speed profile block: position in, command out.
interface tsp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] travelled;

    modport source (output valid, output travelled, input ready);
    modport sink (input valid, input travelled, output ready);
endinterface

interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] command_speed;
    logic [1:0]  phase;

    modport source (output valid, output command_speed, output phase, input ready);
    modport sink (input valid, input command_speed, input phase, output ready);
endinterface

### design/tsp_derive.sv
// Configuration registers and the sequencer that derives peak speed and ramp limits.
module tsp_derive (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsp_pkg::WORD_W-1:0]   cfg_data,
    output tsp_pkg::cfg_t                cfg,
    output tsp_pkg::derive_t             drv
);
    import tsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_VMAX,
        S_SQ_VBEG,
        S_SQ_VEND,
        S_MUL_AD,
        S_DIV_ACC,
        S_DIV_DEC,
        S_CHOOSE,
        S_ROOT,
        S_SQ_PEAK,
        S_DIV_TRI
    } state_t;

    localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);
    localparam logic [5:0] ROOT_LAST = 6'(ROOT_STEPS - 1);

    state_t                   state_reg;
    cfg_t                     cfg_reg;
    logic [5:0]               cnt_reg;
    logic [SQ_W-1:0]          vmax2_reg;
    logic [SQ_W-1:0]          vbeg2_reg;
    logic [SQ_W-1:0]          vend2_reg;
    logic [SQ_W-1:0]          ad_reg;
    logic [SQ_W-1:0]          div_q_reg;
    logic [WORD_W+1:0]        div_rem_reg;
    logic                     div_neg_reg;
    logic signed [DIST_W-1:0] d_acc_reg;
    logic signed [DIST_W-1:0] d_dec_reg;
    logic [WORD_W-1:0]        peak_reg;
    logic signed [DIST_W-1:0] accel_end_reg;
    logic signed [DIST_W-1:0] decel_start_reg;
    root_st_t                 root_reg;

    logic [WORD_W-1:0]        mul_a;
    logic [WORD_W-1:0]        mul_b;
    logic [SQ_W-1:0]          prod;
    logic [SQ_W-1:0]          ld_hi;
    logic [SQ_W-1:0]          ld_lo;
    logic                     ld_neg;
    logic [SQ_W-1:0]          ld_mag;
    logic [WORD_W:0]          two_a;
    logic [WORD_W+1:0]        div_cur;
    logic                     div_ge;
    logic [WORD_W+1:0]        div_rem_n;
    logic [SQ_W-1:0]          div_q_n;
    logic [DIST_W-1:0]        q_ext;
    logic signed [DIST_W-1:0] div_res;
    logic signed [DIST_W:0]   ramp_sum;
    logic signed [DIST_W-1:0] dist_s;
    logic signed [DIST_W-1:0] trap_decel;
    logic [SQ_W:0]            half_sum;
    logic [SQ_W:0]            tri_sum;
    logic [SQ_W-1:0]          tri_arg;
    root_st_t                 root_n;
    logic [WORD_W-1:0]        lo_speed;
    logic [WORD_W-1:0]        peak_lo;
    logic [WORD_W-1:0]        peak_clamped;

    always_comb
    begin
        case (state_reg)
            S_SQ_VMAX:
            begin
                mul_a = cfg_reg.vmax;
                mul_b = cfg_reg.vmax;
            end
            S_SQ_VBEG:
            begin
                mul_a = cfg_reg.vbeg;
                mul_b = cfg_reg.vbeg;
            end
            S_SQ_VEND:
            begin
                mul_a = cfg_reg.vend;
                mul_b = cfg_reg.vend;
            end
            S_MUL_AD:
            begin
                mul_a = cfg_reg.acc;
                mul_b = cfg_reg.span;
            end
            default:
            begin
                mul_a = peak_reg;
                mul_b = peak_reg;
            end
        endcase
        prod = SQ_W'(mul_a) * SQ_W'(mul_b);

        case (state_reg)
            S_MUL_AD:
            begin
                ld_hi = vmax2_reg;
                ld_lo = vbeg2_reg;
            end
            S_DIV_ACC:
            begin
                ld_hi = vmax2_reg;
                ld_lo = vend2_reg;
            end
            default:
            begin
                ld_hi = prod;
                ld_lo = vbeg2_reg;
            end
        endcase
        ld_neg = ld_hi < ld_lo;
        ld_mag = ld_neg ? (ld_lo - ld_hi) : (ld_hi - ld_lo);

        two_a     = {cfg_reg.acc, 1'b0};
        div_cur   = {div_rem_reg[WORD_W:0], div_q_reg[SQ_W-1]};
        div_ge    = div_cur >= {1'b0, two_a};
        div_rem_n = div_ge ? (div_cur - {1'b0, two_a}) : div_cur;
        div_q_n   = {div_q_reg[SQ_W-2:0], div_ge};
        q_ext     = {1'b0, div_q_n};
        div_res   = div_neg_reg ? $signed(DIST_W'(0) - q_ext) : $signed(q_ext);

        dist_s     = $signed({{(DIST_W-WORD_W){1'b0}}, cfg_reg.span});
        ramp_sum   = {d_acc_reg[DIST_W-1], d_acc_reg} + {d_dec_reg[DIST_W-1], d_dec_reg};
        trap_decel = dist_s - d_dec_reg;
        half_sum   = {1'b0, vbeg2_reg} + {1'b0, vend2_reg};
        tri_sum    = {1'b0, ad_reg} + {1'b0, half_sum[SQ_W:1]};
        tri_arg    = tri_sum[SQ_W] ? {SQ_W{1'b1}} : tri_sum[SQ_W-1:0];

        root_n       = root_step(root_reg);
        lo_speed     = (cfg_reg.vbeg > cfg_reg.vend) ? cfg_reg.vbeg : cfg_reg.vend;
        peak_lo      = (root_n.root < lo_speed) ? lo_speed : root_n.root;
        peak_clamped = (peak_lo > cfg_reg.vmax) ? cfg_reg.vmax : peak_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DIST: cfg_reg.span <= cfg_data;
                REG_VMAX: cfg_reg.vmax <= cfg_data;
                REG_ACC:  cfg_reg.acc  <= cfg_data;
                REG_VEND: cfg_reg.vend <= cfg_data;
                REG_VBEG: cfg_reg.vbeg <= cfg_data;
                default:  cfg_reg      <= cfg_reg;
            endcase
            state_reg <= S_SQ_VMAX;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    state_reg <= S_IDLE;
                end
                S_SQ_VMAX:
                begin
                    vmax2_reg <= prod;
                    state_reg <= S_SQ_VBEG;
                end
                S_SQ_VBEG:
                begin
                    vbeg2_reg <= prod;
                    state_reg <= S_SQ_VEND;
                end
                S_SQ_VEND:
                begin
                    vend2_reg <= prod;
                    state_reg <= S_MUL_AD;
                end
                S_MUL_AD:
                begin
                    ad_reg      <= prod;
                    div_q_reg   <= ld_mag;
                    div_rem_reg <= '0;
                    div_neg_reg <= ld_neg;
                    cnt_reg     <= '0;
                    state_reg   <= S_DIV_ACC;
                end
                S_DIV_ACC:
                begin
                    div_q_reg   <= div_q_n;
                    div_rem_reg <= div_rem_n;
                    cnt_reg     <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        d_acc_reg   <= div_res;
                        div_q_reg   <= ld_mag;
                        div_rem_reg <= '0;
                        div_neg_reg <= ld_neg;
                        cnt_reg     <= '0;
                        state_reg   <= S_DIV_DEC;
                    end
                end
                S_DIV_DEC:
                begin
                    div_q_reg   <= div_q_n;
                    div_rem_reg <= div_rem_n;
                    cnt_reg     <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        d_dec_reg <= div_res;
                        cnt_reg   <= '0;
                        state_reg <= S_CHOOSE;
                    end
                end
                S_CHOOSE:
                begin
                    if (ramp_sum <= $signed({dist_s[DIST_W-1], dist_s}))
                    begin
                        peak_reg        <= cfg_reg.vmax;
                        accel_end_reg   <= d_acc_reg;
                        decel_start_reg <= trap_decel;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        root_reg  <= '{rem: '0, root: '0, x: tri_arg};
                        cnt_reg   <= '0;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    root_reg <= root_n;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == ROOT_LAST)
                    begin
                        peak_reg  <= peak_clamped;
                        cnt_reg   <= '0;
                        state_reg <= S_SQ_PEAK;
                    end
                end
                S_SQ_PEAK:
                begin
                    div_q_reg   <= ld_mag;
                    div_rem_reg <= '0;
                    div_neg_reg <= ld_neg;
                    cnt_reg     <= '0;
                    state_reg   <= S_DIV_TRI;
                end
                S_DIV_TRI:
                begin
                    div_q_reg   <= div_q_n;
                    div_rem_reg <= div_rem_n;
                    cnt_reg     <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        accel_end_reg   <= div_res;
                        decel_start_reg <= div_res;
                        cnt_reg         <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg             = cfg_reg;
    assign drv.degenerate  = (cfg_reg.span == '0) || (cfg_reg.acc == '0);
    assign drv.busy        = state_reg != S_IDLE;
    assign drv.peak        = peak_reg;
    assign drv.accel_end   = accel_end_reg;
    assign drv.decel_start = decel_start_reg;
    assign drv.vbeg2       = vbeg2_reg;
    assign drv.vend2       = vend2_reg;

endmodule

### design/tsp_front.sv
// Front end: accept positions, clamp and classify them, form the root argument.
module tsp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  tsp_pkg::cfg_t    cfg,
    input  tsp_pkg::derive_t drv,
    tsp_in_if.sink           sample,
    output logic             push_valid,
    input  logic             push_ready,
    output tsp_pkg::q_item_t push_item
);
    import tsp_pkg::*;

    typedef struct packed {
        phase_t            phase;
        logic              use_root;
        logic              sel_vend;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] direct;
    } cls_t;

    logic              f1_v_reg;
    cls_t              f1_reg;
    logic              f2_v_reg;
    cls_t              f2_reg;
    logic [SQ_W-1:0]   prod_reg;

    logic [WORD_W-1:0]        raw;
    logic [WORD_W-1:0]        pos;
    logic signed [DIST_W-1:0] pos_s;
    cls_t                     cls;
    logic                     f1_adv;
    logic                     f2_adv;
    logic                     accept;
    logic [SQ_W-1:0]          v2;
    logic [SQ_W+1:0]          sum;

    always_comb
    begin
        raw   = sample.travelled;
        pos   = raw[WORD_W-1] ? '0 : ((raw < cfg.span) ? raw : cfg.span);
        pos_s = $signed({{(DIST_W-WORD_W){1'b0}}, pos});
        cls   = '{phase: PH_DONE, use_root: 1'b0, sel_vend: 1'b0, d: '0, direct: cfg.vend};
        if (drv.degenerate || (pos >= cfg.span))
        begin
            cls.phase = PH_DONE;
        end
        else if (pos_s < drv.accel_end)
        begin
            cls.phase    = PH_ACCEL;
            cls.use_root = 1'b1;
            cls.d        = pos;
        end
        else if (pos_s < drv.decel_start)
        begin
            cls.phase  = PH_CRUISE;
            cls.direct = drv.peak;
        end
        else
        begin
            cls.phase    = PH_DECEL;
            cls.use_root = 1'b1;
            cls.sel_vend = 1'b1;
            cls.d        = cfg.span - pos;
        end
    end

    assign f2_adv       = !f2_v_reg || push_ready;
    assign f1_adv       = !f1_v_reg || f2_adv;
    assign sample.ready = f1_adv && !drv.busy;
    assign accept       = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else
        begin
            if (f1_adv)
            begin
                f1_v_reg <= accept;
            end
            if (f2_adv)
            begin
                f2_v_reg <= f1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_adv && accept)
        begin
            f1_reg <= cls;
        end
        if (f2_adv && f1_v_reg)
        begin
            f2_reg   <= f1_reg;
            prod_reg <= SQ_W'(cfg.acc) * SQ_W'(f1_reg.d);
        end
    end

    always_comb
    begin
        v2  = f2_reg.sel_vend ? drv.vend2 : drv.vbeg2;
        sum = {2'b00, v2} + {1'b0, prod_reg, 1'b0};
        push_item.phase    = f2_reg.phase;
        push_item.use_root = f2_reg.use_root;
        push_item.direct   = f2_reg.direct;
        push_item.arg      = (sum[SQ_W+1:SQ_W] != 2'b00) ? {SQ_W{1'b1}} : sum[SQ_W-1:0];
    end

    assign push_valid = f2_v_reg;

endmodule

### design/tsp_queue.sv
// Short queue between the classifying front end and the root pipeline.
module tsp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  tsp_pkg::q_item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output tsp_pkg::q_item_t pop_item
);
    import tsp_pkg::*;

    q_item_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

### design/tsp_back.sv
// Back end: pipelined square root, peak cap and the output register.
module tsp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tsp_pkg::derive_t drv,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  tsp_pkg::q_item_t pop_item,
    tsp_out_if.source        command
);
    import tsp_pkg::*;

    root_st_t          st_reg  [ROOT_STEPS];
    root_st_t          st_next [ROOT_STEPS];
    logic              v_reg   [ROOT_STEPS];
    phase_t            ph_reg  [ROOT_STEPS];
    logic              use_reg [ROOT_STEPS];
    logic [WORD_W-1:0] dir_reg [ROOT_STEPS];

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_speed_reg;
    phase_t            out_phase_reg;
    logic              adv;
    logic [WORD_W-1:0] root_last;

    assign adv       = !out_valid_reg || command.ready;
    assign pop_ready = adv;

    always_comb
    begin
        st_next[0] = root_step('{rem: '0, root: '0, x: pop_item.arg});
        for (int k = 1; k < ROOT_STEPS; k++)
        begin
            st_next[k] = root_step(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= pop_valid;
            for (int k = 1; k < ROOT_STEPS; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            out_valid_reg <= v_reg[ROOT_STEPS-1];
        end
    end

    assign root_last = st_reg[ROOT_STEPS-1].root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]  <= st_next[0];
            ph_reg[0]  <= pop_item.phase;
            use_reg[0] <= pop_item.use_root;
            dir_reg[0] <= pop_item.direct;
            for (int k = 1; k < ROOT_STEPS; k++)
            begin
                st_reg[k]  <= st_next[k];
                ph_reg[k]  <= ph_reg[k-1];
                use_reg[k] <= use_reg[k-1];
                dir_reg[k] <= dir_reg[k-1];
            end
            out_phase_reg <= ph_reg[ROOT_STEPS-1];
            if (use_reg[ROOT_STEPS-1])
            begin
                out_speed_reg <= (root_last < drv.peak) ? root_last : drv.peak;
            end
            else
            begin
                out_speed_reg <= dir_reg[ROOT_STEPS-1];
            end
        end
    end

    assign command.valid         = out_valid_reg;
    assign command.command_speed = out_speed_reg;
    assign command.phase         = out_phase_reg;

endmodule

### design/trapezoidal_speed_profile.sv
// Top level of the position-based trapezoidal speed profile.
//   channel   direction  payload
//   sample    in         travelled (signed Q16.16)
//   command   out        command_speed (Q16.16), phase
//   cfg_*     in         write enable, register index, 32-bit data
// One position per cycle is taken unless back-pressure or a limit rebuild holds sample.ready low.
// The square root of each request runs through a 32-stage pipeline, one root bit per stage.
// After any register write, a sequencer with one multiplier, a bit-serial divider and an
// iterative root rebuilds the move limits; sample.ready stays low meanwhile.
// A stalled command holds the root pipeline; the queue and front stages then fill before
// sample.ready drops. Reset clears the configuration registers to zero and empties the pipeline.
module trapezoidal_speed_profile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsp_pkg::WORD_W-1:0]    cfg_data,
    tsp_in_if.sink                        sample,
    tsp_out_if.source                     command
);
    import tsp_pkg::*;

    cfg_t    cfg;
    derive_t drv;
    logic    push_valid;
    logic    push_ready;
    q_item_t push_item;
    logic    pop_valid;
    logic    pop_ready;
    q_item_t pop_item;

    tsp_derive u_derive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .drv       (drv)
    );

    tsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .drv        (drv),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    tsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    tsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .drv       (drv),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .command   (command)
    );

`ifndef SYNTHESIS
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !sample.ready)
        else $error("sample accepted while limits are rebuilt");

    a_cruise_is_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (command.valid && (phase_t'(command.phase) == PH_CRUISE))
            |-> (command.command_speed == drv.peak))
        else $error("cruise speed differs from peak");

    a_ramp_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (command.valid && (phase_t'(command.phase) != PH_DONE))
            |-> (command.command_speed <= drv.peak))
        else $error("commanded speed above peak");
`endif

endmodule

### tb/tb_trapezoidal_speed_profile.sv
// Self-checking testbench of the trapezoidal speed profile: random moves, positions and handshake gaps.
module tb_trapezoidal_speed_profile;
    import tsp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] UNUSED_IDX = 3'd7;

    typedef struct {
        logic [31:0] span;
        logic [31:0] vmax;
        logic [31:0] acc;
        logic [31:0] vend;
        logic [31:0] vbeg;
    } move_t;

    typedef struct {
        logic [31:0] speed;
        phase_t      phase;
    } command_t;

    class profile_scoreboard;
        command_t pending[$];

        static function logic [63:0] floor_root(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        static function longint ramp_length(logic [63:0] hi2, logic [63:0] lo2,
                                            logic [63:0] two_a);
            if (hi2 >= lo2)
                return longint'((hi2 - lo2) / two_a);
            return -longint'((lo2 - hi2) / two_a);
        endfunction

        static function longint clamp_sum(longint x, longint y);
            logic signed [65:0] s;
            s = 66'(x) + 66'(y);
            if (s > 66'sh0_7FFF_FFFF_FFFF_FFFF)
                return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (s < -66'sh0_8000_0000_0000_0000)
                return 64'sh8000_0000_0000_0000;
            return longint'(s);
        endfunction

        static function logic [63:0] add_clamped(logic [63:0] x, logic [63:0] y);
            logic [64:0] s;
            s = {1'b0, x} + {1'b0, y};
            return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
        endfunction

        static function logic [63:0] ramp_speed(logic [63:0] v2, logic [63:0] a,
                                                logic [63:0] d, logic [63:0] cap);
            logic [63:0] prod;
            logic [63:0] s;
            prod = a * d;
            prod = prod[63] ? 64'hFFFF_FFFF_FFFF_FFFF : prod << 1;
            s = floor_root(add_clamped(v2, prod));
            return (s < cap) ? s : cap;
        endfunction

        static function command_t speed_at(move_t m, logic [31:0] raw);
            command_t    c;
            logic [63:0] span, vmax, acc, vend, vbeg;
            logic [63:0] two_a, vmax2, vbeg2, vend2, peak, pos, speed, half, lo;
            longint      d_acc, d_dec, accel_end, decel_start;
            span = m.span;
            vmax = m.vmax;
            acc  = m.acc;
            vend = m.vend;
            vbeg = m.vbeg;
            c.speed = m.vend;
            c.phase = PH_DONE;
            if (span == 0 || acc == 0)
                return c;
            two_a = acc * 2;
            vmax2 = vmax * vmax;
            vbeg2 = vbeg * vbeg;
            vend2 = vend * vend;
            d_acc = ramp_length(vmax2, vbeg2, two_a);
            d_dec = ramp_length(vmax2, vend2, two_a);
            if (clamp_sum(d_acc, d_dec) <= longint'(span))
            begin
                peak = vmax;
                accel_end = d_acc;
                decel_start = clamp_sum(longint'(span), -d_dec);
            end
            else
            begin
                half = (vbeg2 >> 1) + (vend2 >> 1) + (vbeg2 & vend2 & 64'd1);
                lo = (vbeg > vend) ? vbeg : vend;
                peak = floor_root(add_clamped(acc * span, half));
                if (peak < lo)
                    peak = lo;
                if (peak > vmax)
                    peak = vmax;
                accel_end = ramp_length(peak * peak, vbeg2, two_a);
                decel_start = accel_end;
            end
            pos = raw[31] ? 64'd0 : ((64'(raw) < span) ? 64'(raw) : span);
            if (pos >= span)
                return c;
            if (longint'(pos) < accel_end)
            begin
                speed = ramp_speed(vbeg2, acc, pos, peak);
                c.phase = PH_ACCEL;
            end
            else if (longint'(pos) < decel_start)
            begin
                speed = peak;
                c.phase = PH_CRUISE;
            end
            else
            begin
                speed = ramp_speed(vend2, acc, span - pos, peak);
                c.phase = PH_DECEL;
            end
            if (speed > vmax)
                speed = vmax;
            c.speed = speed[31:0];
            return c;
        endfunction

        function void note_request(move_t m, logic [31:0] raw);
            pending.push_back(speed_at(m, raw));
        endfunction

        // 0 match, 1 nothing pending, 2 field mismatch
        function int check_command(logic [31:0] speed, phase_t ph, output command_t want);
            want.speed = 0;
            want.phase = PH_ACCEL;
            if (pending.size() == 0)
                return 1;
            want = pending.pop_front();
            return (want.speed === speed && want.phase === ph) ? 0 : 2;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    tsp_in_if  sample_ch ();
    tsp_out_if command_ch ();

    trapezoidal_speed_profile dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch.sink),
        .command   (command_ch.source)
    );

    profile_scoreboard board;
    move_t  shadow;
    int     errors;
    int     requests;
    int     commands;
    int     moves;
    int     gap_pct;
    int     stall_pct;

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("tb_trapezoidal_speed_profile: errors");
        $finish;
    end

    task automatic report(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        command_t want;
        int       code;
        if (rst_n && command_ch.valid && command_ch.ready)
        begin
            commands++;
            code = board.check_command(command_ch.command_speed,
                                       phase_t'(command_ch.phase), want);
            if (code == 1)
                report($sformatf("unexpected command speed %h phase %0d",
                                 command_ch.command_speed, command_ch.phase));
            else if (code == 2)
                report($sformatf("speed %h phase %0d, expected speed %h phase %0d",
                                 command_ch.command_speed, command_ch.phase,
                                 want.speed, want.phase));
        end
        command_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_DIST: shadow.span = value;
            REG_VMAX: shadow.vmax = value;
            REG_ACC:  shadow.acc  = value;
            REG_VEND: shadow.vend = value;
            REG_VBEG: shadow.vbeg = value;
            default: ;
        endcase
    endtask

    task automatic drain;
        sample_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic load_move(logic [31:0] d, logic [31:0] vm, logic [31:0] a,
                             logic [31:0] vf, logic [31:0] vs);
        drain();
        write_reg(REG_DIST, d);
        write_reg(REG_VMAX, vm);
        write_reg(REG_ACC, a);
        write_reg(REG_VEND, vf);
        write_reg(REG_VBEG, vs);
        if ($urandom_range(3) == 0)
            write_reg(UNUSED_IDX, $urandom);
        cfg_we <= 1'b0;
        moves++;
    endtask

    task automatic send_position(logic [31:0] raw);
        if ($urandom_range(99) < gap_pct)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.travelled <= raw;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        board.note_request(shadow, raw);
        requests++;
    endtask

    function automatic logic [31:0] pick_position();
        int          sel;
        logic [31:0] top;
        sel = $urandom_range(99);
        top = (shadow.span > 32'h7000_0000) ? 32'h7FFF_FFFF : shadow.span + shadow.span / 8 + 2;
        if (sel < 70)
            return $urandom_range(top, 0);
        if (sel < 80)
            return 32'h8000_0000 | $urandom;
        if (sel < 88)
            return shadow.span + $urandom_range(2, 0) - 1;
        return $urandom;
    endfunction

    task automatic random_move;
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            load_move($urandom_range(32'h0040_0000, 1), $urandom_range(32'h0008_0000),
                      $urandom_range(32'h0004_0000, 1), $urandom_range(32'h0006_0000),
                      $urandom_range(32'h0006_0000));
        else if (sel < 8)
            load_move($urandom, $urandom, $urandom, $urandom, $urandom);
        else
            load_move($urandom_range(32'h0010_0000), $urandom_range(32'h0002_0000),
                      $urandom_range(32'h0000_0400), $urandom_range(32'h0004_0000),
                      $urandom_range(32'h0004_0000));
    endtask

    task automatic set_idling(int mode);
        gap_pct   = (mode == 1) ? 48 : (mode == 3) ? 31 : 0;
        stall_pct = (mode == 2) ? 48 : (mode == 3) ? 31 : 0;
    endtask

    initial
    begin
        board = new();
        shadow = '{default: 32'd0};
        errors = 0;
        requests = 0;
        commands = 0;
        moves = 0;
        set_idling(0);
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DIST;
        cfg_data = 32'd0;
        sample_ch.valid = 1'b0;
        sample_ch.travelled = 32'sd0;
        command_ch.ready = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: degenerate move
        send_position(32'd0);
        send_position(32'h7FFF_FFFF);
        load_move(32'h0010_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_8000, 32'h0001_0000);
        send_position(32'h0000_1000);
        load_move(32'h0000_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
        send_position(32'h0000_1000);
        // trapezoid with cruise
        load_move(32'h0040_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
        send_position(32'h8000_0000);
        send_position(32'hFFFF_FFFF);
        send_position(32'd0);
        send_position(32'd1);
        send_position(32'h0000_2000);
        send_position(32'h0020_0000);
        send_position(32'h003F_FFFF);
        send_position(32'h0040_0000);
        send_position(32'h0040_0001);
        send_position(32'h7FFF_FFFF);
        // triangle, then boundary speeds above the limit
        load_move(32'h0000_8000, 32'h0010_0000, 32'h0000_4000, 32'h0000_2000, 32'h0000_1000);
        send_position(32'h0000_1000);
        send_position(32'h0000_4000);
        send_position(32'h0000_7000);
        load_move(32'h0010_0000, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_position(32'h0000_0100);
        send_position(32'h0008_0000);
        send_position(32'h000F_FF00);
        // every register at its maximum
        load_move(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_position(32'h0000_0001);
        send_position(32'h7FFF_FFFF);

        for (int p = 0; p < 12; p++)
        begin
            set_idling(p % 4);
            random_move();
            repeat (50)
                send_position(pick_position());
        end
        sample_ch.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
        $display("covered %0d moves, %0d positions sent, %0d commands checked",
                 moves, requests, commands);
        $display("idling phases: none, sender gaps, receiver stalls, both");
        if (errors == 0 && board.pending.size() == 0)
            $display("tb_trapezoidal_speed_profile: clean");
        else
            $display("tb_trapezoidal_speed_profile: errors");
        $finish;
    end

endmodule

### trapezoidal_speed_profile.f
design/tsp_pkg.sv
design/tsp_if.sv
design/tsp_derive.sv
design/tsp_front.sv
design/tsp_queue.sv
design/tsp_back.sv
design/trapezoidal_speed_profile.sv
tb/tb_trapezoidal_speed_profile.sv
